// ===== rtl/fdet_pkg.sv =====
package fdet_pkg;

  localparam int MAX_EXTENTS_DEF = 16;
  localparam int MAX_STRIPS_DEF  = 16;
  localparam int MAX_DEVICES_DEF = 8;
  localparam int OFFSET_BITS_DEF = 48;

  typedef enum logic [1:0] {
    REQ_LOAD_EXTENT = 2'd0,
    REQ_LOAD_STRIP  = 2'd1,
    REQ_DEV_STATUS  = 2'd2,
    REQ_TRANSLATE   = 2'd3
  } req_type_t;

  typedef enum logic [2:0] {
    ST_MAPPED   = 3'd0,
    ST_PAST_END = 3'd1,
    ST_DEV_INV  = 3'd2,
    ST_DEV_ERR  = 3'd3,
    ST_UNUSABLE = 3'd4,
    ST_ZERO_EXT = 3'd5
  } map_status_t;

  localparam logic [1:0] CFG_FSIZE        = 2'd0;
  localparam logic [1:0] CFG_INTERLEAVED  = 2'd1;
  localparam logic [1:0] CFG_EXTENT_COUNT = 2'd2;
  localparam logic [1:0] CFG_FILE_USABLE  = 2'd3;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [3:0]  slot_index;
    logic [3:0]  strip_index;
    logic [2:0]  dev_num;
    logic [47:0] item_offset;
    logic [47:0] item_length;
    logic [32:0] chunk_bytes;
    logic [4:0]  strip_count;
    logic        dev_valid;
    logic        dev_error;
    logic [31:0] access_flags;
  } in_item_t;

  typedef struct packed {
    logic [47:0] dax_address;
    logic [47:0] map_file_offset;
    logic [47:0] map_length;
    logic [2:0]  map_device;
    logic [2:0]  map_status;
    logic [31:0] out_flags;
  } out_item_t;

endpackage

// ===== rtl/file_to_device_extent_translate.sv =====
// Channel | Dir | Handshake             | Payload
// in_     | in  | in_valid / in_stall   | fdet_pkg::in_item_t
// out_    | out | out_valid / out_stall | fdet_pkg::out_item_t
// cfg_    | in  | cfg_valid / cfg_ready | cfg_index, cfg_data
// Loads and status writes complete at the accept edge; the next item may follow at once.
// After the accept edge a translate walks the extents in S_EXT_RD and S_EXT_CHK; in
// interleaved mode it then runs two bit-serial dividers (S_DIV1, S_DIV2) and a strip read.
// Past end and file unusable end in S_DONE. A result held by out_stall delays the next.
// Reset is synchronous, clears control and device flags; tables stay as is.
// The input stalls while a translate runs and while a result is valid on the output.
module file_to_device_extent_translate #(
  parameter int MAX_EXTENTS = fdet_pkg::MAX_EXTENTS_DEF,
  parameter int MAX_STRIPS  = fdet_pkg::MAX_STRIPS_DEF,
  parameter int MAX_DEVICES = fdet_pkg::MAX_DEVICES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  fdet_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output fdet_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [47:0]         cfg_data
);
  import fdet_pkg::*;

  localparam int EW  = (MAX_EXTENTS > 1) ? $clog2(MAX_EXTENTS) : 1;
  localparam int SW  = (MAX_STRIPS > 1) ? $clog2(MAX_STRIPS) : 1;
  localparam int DW  = (MAX_DEVICES > 1) ? $clog2(MAX_DEVICES) : 1;
  localparam int TW  = EW + SW;
  localparam int OB  = OFFSET_BITS_DEF;
  localparam int CW  = $clog2(OB + 2);

  typedef enum logic [3:0] {
    S_IDLE, S_EXT_RD, S_EXT_CHK, S_DIV1, S_DIV2, S_STRIP_RD, S_STRIP_USE, S_DONE
  } state_t;

  typedef struct packed {
    logic [47:0] base;
    logic [47:0] length;
    logic [2:0]  dev;
    logic [32:0] chunk;
    logic [4:0]  strips;
  } ext_ent_t;

  typedef struct packed {
    logic [47:0] base;
    logic [2:0]  dev;
  } strip_ent_t;

  // Memories
  ext_ent_t   ext_mem [2**EW];
  strip_ent_t strip_mem [2**TW];
  ext_ent_t   ext_rd_r;
  strip_ent_t strip_rd_r;
  logic [MAX_DEVICES-1:0] dev_ok_r, dev_fail_r;

  // Config registers
  logic [47:0] fsize_r;
  logic        ileave_r, usable_r;
  logic [4:0]  ext_count_r;

  state_t      state_r;
  in_item_t    req_r;
  logic [OB-1:0] local_r;
  logic [EW:0]   idx_r;
  logic [EW:0]   n_ext;
  out_item_t   out_r;
  logic        out_valid_r;
  logic [2:0]  fail_st_r;
  logic        emit_ok;

  // Divider datapath: quotient in q_r, remainder in rem_r
  logic [OB-1:0] q_r;
  logic [OB:0]   rem_r;
  logic [CW-1:0] cnt_r;
  logic [OB-1:0] co_r;
  // Stripe times chunk size, built from the stripe quotient bits
  logic [OB-1:0] prod_r;

  logic [47:0] ext_span;
  logic [OB:0] rem_sh, dvs1, dvs2;
  logic [TW-1:0] strip_addr;
  logic [2:0]  sel_dev;
  logic [47:0] sel_base;
  logic [2:0]  dchk;
  logic [47:0] cap_len;

  assign n_ext = (32'(ext_count_r) > MAX_EXTENTS) ? (EW+1)'(MAX_EXTENTS)
                                                  : (EW+1)'(ext_count_r);
  assign ext_span = (ileave_r && fsize_r < ext_rd_r.length) ? fsize_r
                                                            : ext_rd_r.length;
  assign dvs1 = (OB+1)'(ext_rd_r.chunk);
  assign dvs2 = (OB+1)'(ext_rd_r.strips);
  assign rem_sh = {rem_r[OB-1:0], q_r[OB-1]};
  assign strip_addr = {idx_r[EW-1:0], rem_r[SW-1:0]};

  assign in_stall  = (state_r != S_IDLE) || out_valid_r;
  assign cfg_ready = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign emit_ok   = (state_r inside {S_STRIP_USE, S_DONE}) && (!out_valid_r || !out_stall);

  // Pick mapped device and base for the device check
  always_comb begin
    if (ileave_r) begin
      sel_dev  = strip_rd_r.dev;
      sel_base = 48'(OB'(strip_rd_r.base) + co_r + prod_r);
      cap_len  = 48'(ext_rd_r.chunk - 33'(co_r));
    end else begin
      sel_dev  = ext_rd_r.dev;
      sel_base = 48'(OB'(ext_rd_r.base) + local_r);
      cap_len  = 48'(ext_span - 48'(local_r));
    end
    if (32'(sel_dev) >= MAX_DEVICES) dchk = ST_DEV_INV;
    else if (!dev_ok_r[DW'(sel_dev)]) dchk = ST_DEV_INV;
    else if (dev_fail_r[DW'(sel_dev)]) dchk = ST_DEV_ERR;
    else dchk = ST_MAPPED;
  end

  // Memory ports
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_valid && !in_stall) begin
      if (in_data.req_type == REQ_LOAD_EXTENT && 32'(in_data.slot_index) < MAX_EXTENTS)
        ext_mem[EW'(in_data.slot_index)] <= '{in_data.item_offset, in_data.item_length,
          in_data.dev_num, in_data.chunk_bytes, in_data.strip_count};
      if (in_data.req_type == REQ_LOAD_STRIP && 32'(in_data.slot_index) < MAX_EXTENTS
          && 32'(in_data.strip_index) < MAX_STRIPS)
        strip_mem[{EW'(in_data.slot_index), SW'(in_data.strip_index)}] <=
          '{in_data.item_offset, in_data.dev_num};
    end
    ext_rd_r   <= ext_mem[idx_r[EW-1:0]];
    strip_rd_r <= strip_mem[strip_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      dev_ok_r    <= '0;
      dev_fail_r  <= '0;
      fsize_r     <= '0;
      ileave_r    <= 1'b0;
      usable_r    <= 1'b0;
      ext_count_r <= 5'd1;
      idx_r       <= '0;
    end else begin
      if (out_valid_r && !out_stall && !emit_ok) out_valid_r <= 1'b0;
      // Take register writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_FSIZE:        fsize_r     <= cfg_data;
          CFG_INTERLEAVED:  ileave_r    <= cfg_data[0];
          CFG_EXTENT_COUNT: ext_count_r <= cfg_data[4:0];
          CFG_FILE_USABLE:  usable_r    <= cfg_data[0];
          default: ;
        endcase
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid && !in_stall) begin
            req_r   <= in_data;
            local_r <= OB'(in_data.item_offset);
            idx_r   <= '0;
            if (in_data.req_type == REQ_DEV_STATUS && 32'(in_data.dev_num) < MAX_DEVICES) begin
              dev_ok_r[DW'(in_data.dev_num)]   <= in_data.dev_valid;
              dev_fail_r[DW'(in_data.dev_num)] <= in_data.dev_error;
            end
            if (in_data.req_type == REQ_TRANSLATE) state_r <= S_EXT_RD;
          end
        end
        S_EXT_RD: begin
          // wait for extent read data; fail if the file is unusable or past the last extent
          if (!usable_r) begin
            fail_st_r <= ST_UNUSABLE; state_r <= S_DONE;
          end else if (idx_r >= n_ext) begin
            fail_st_r <= ST_PAST_END; state_r <= S_DONE;
          end else state_r <= S_EXT_CHK;
        end
        S_EXT_CHK: begin
          if (ileave_r && ext_span == '0) begin
            fail_st_r <= ST_ZERO_EXT; state_r <= S_DONE;
          end else if (48'(local_r) < ext_span) begin
            if (!ileave_r) state_r <= S_STRIP_USE;
            else if (ext_rd_r.chunk == '0 || ext_rd_r.strips == '0 ||
                     32'(ext_rd_r.strips) > MAX_STRIPS) begin
              fail_st_r <= ST_UNUSABLE; state_r <= S_DONE;
            end else begin
              q_r <= local_r; rem_r <= '0; cnt_r <= CW'(OB); state_r <= S_DIV1;
            end
          end else begin
            local_r <= OB'(48'(local_r) - ext_span);
            idx_r   <= idx_r + 1'b1;
            state_r <= S_EXT_RD;
          end
        end
        S_DIV1: begin
          // restoring divide, one quotient bit per cycle
          if (cnt_r == '0) begin
            co_r <= rem_r[OB-1:0];
            prod_r <= '0;
            rem_r <= '0; cnt_r <= CW'(OB); state_r <= S_DIV2;
          end else begin
            if (rem_sh >= dvs1) begin
              rem_r <= rem_sh - dvs1; q_r <= {q_r[OB-2:0], 1'b1};
            end else begin
              rem_r <= rem_sh; q_r <= {q_r[OB-2:0], 1'b0};
            end
            cnt_r <= cnt_r - 1'b1;
          end
        end
        S_DIV2: begin
          // accumulate stripe * chunk alongside the stripe quotient bits
          if (cnt_r == '0) state_r <= S_STRIP_RD;
          else begin
            if (rem_sh >= dvs2) begin
              rem_r <= rem_sh - dvs2; q_r <= {q_r[OB-2:0], 1'b1};
              prod_r <= {prod_r[OB-2:0], 1'b0} + OB'(ext_rd_r.chunk);
            end else begin
              rem_r <= rem_sh; q_r <= {q_r[OB-2:0], 1'b0};
              prod_r <= {prod_r[OB-2:0], 1'b0};
            end
            cnt_r <= cnt_r - 1'b1;
          end
        end
        S_STRIP_RD: state_r <= S_STRIP_USE;
        S_STRIP_USE: begin
          if (emit_ok) begin
            out_valid_r <= 1'b1;
            out_r.map_file_offset <= req_r.item_offset;
            out_r.out_flags <= req_r.access_flags;
            out_r.map_status <= dchk;
            if (dchk == ST_MAPPED) begin
              out_r.dax_address <= sel_base;
              out_r.map_length  <= (req_r.item_length < cap_len) ? req_r.item_length : cap_len;
              out_r.map_device  <= sel_dev;
            end else begin
              out_r.dax_address <= '0; out_r.map_length <= '0; out_r.map_device <= '0;
            end
            state_r <= S_IDLE;
          end
        end
        S_DONE: begin
          if (emit_ok) begin
            out_valid_r <= 1'b1;
            out_r <= '{48'd0, req_r.item_offset, 48'd0, 3'd0, fail_st_r,
                       req_r.access_flags};
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  ap_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> in_stall) else $error("accept while busy");
  ap_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> (out_valid_r && $stable(out_r)))
    else $error("result dropped");
  ap_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_ready |-> (state_r == S_IDLE)) else $error("cfg while busy");
  ap_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.map_status != ST_MAPPED) |-> (out_r.map_length == '0))
    else $error("failure with length");
endmodule

// ===== verif/file_to_device_extent_translate_checker.sv =====
`timescale 1ns / 100ps

module file_to_device_extent_translate_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_stall,
  input  fdet_pkg::in_item_t  in_data,
  input  logic                out_valid,
  input  logic                out_stall,
  input  fdet_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [47:0]         cfg_data,
  output int                  mismatches,
  output int                  pending
);
  import fdet_pkg::*;

  localparam int NEXT = MAX_EXTENTS_DEF;
  localparam int NSTR = MAX_STRIPS_DEF;
  localparam int NDEV = MAX_DEVICES_DEF;
  localparam logic [63:0] ADDR_MASK = (64'd1 << OFFSET_BITS_DEF) - 64'd1;

  // Shadow copy of registers and tables
  logic [47:0] fsize;
  logic        interleaved;
  logic [4:0]  extent_count;
  logic        file_usable;

  logic [47:0] ext_base    [NEXT];
  logic [47:0] ext_length  [NEXT];
  logic [2:0]  ext_device  [NEXT];
  logic [32:0] ext_chunk   [NEXT];
  logic [4:0]  ext_strips  [NEXT];
  logic [47:0] strip_base  [NEXT*NSTR];
  logic [2:0]  strip_dev   [NEXT*NSTR];
  logic        dev_ok      [NDEV];
  logic        dev_failed  [NDEV];

  out_item_t expected_maps[$];

  assign pending = expected_maps.size();

  function automatic map_status_t device_status(logic [2:0] d);
    if (d >= NDEV || !dev_ok[d]) return ST_DEV_INV;
    if (dev_failed[d]) return ST_DEV_ERR;
    return ST_MAPPED;
  endfunction

  // Walk the extent list and resolve one file offset
  function automatic map_status_t resolve_offset(input logic [63:0] ofs,
      input logic [63:0] len, output logic [63:0] addr,
      output logic [63:0] mlen, output logic [2:0] dev);
    logic [63:0] n, local_ofs, size, base, rem, cs, ns, cn, co, stripe, strip;
    int idx;
    map_status_t st;
    addr = 0;
    mlen = 0;
    dev = 0;
    if (!file_usable) return ST_UNUSABLE;
    n = (extent_count > 5'(NEXT)) ? 64'(NEXT) : 64'(extent_count);
    local_ofs = ofs;
    for (int i = 0; i < n; i++) begin
      size = 64'(ext_length[i]);
      if (interleaved) begin
        if (64'(fsize) < size) size = 64'(fsize);
        if (size == 0) return ST_ZERO_EXT;
      end
      if (local_ofs < size) begin
        if (!interleaved) begin
          dev = ext_device[i];
          base = 64'(ext_base[i]) + local_ofs;
          rem = size - local_ofs;
        end else begin
          cs = 64'(ext_chunk[i]);
          ns = 64'(ext_strips[i]);
          if (cs == 0 || ns == 0 || ns > NSTR) return ST_UNUSABLE;
          cn = local_ofs / cs;
          co = local_ofs % cs;
          stripe = cn / ns;
          strip = cn % ns;
          idx = i * NSTR + int'(strip);
          dev = strip_dev[idx];
          base = 64'(strip_base[idx]) + co + stripe * cs;
          rem = cs - co;
        end
        st = device_status(dev);
        if (st != ST_MAPPED) begin
          dev = 0;
          return st;
        end
        addr = base & ADDR_MASK;
        mlen = (len < rem) ? len : rem;
        return ST_MAPPED;
      end
      local_ofs -= size;
    end
    return ST_PAST_END;
  endfunction

  // Track configuration and input transactions
  always @(posedge clk) begin
    logic [63:0] addr, mlen;
    logic [2:0] dev;
    map_status_t st;
    out_item_t exp_map;
    if (!rst_n) begin
      fsize <= '0;
      interleaved <= 1'b0;
      extent_count <= 5'd1;
      file_usable <= 1'b0;
      for (int i = 0; i < NDEV; i++) begin
        dev_ok[i] <= 1'b0;
        dev_failed[i] <= 1'b0;
      end
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_FSIZE:        fsize <= cfg_data;
          CFG_INTERLEAVED:  interleaved <= cfg_data[0];
          CFG_EXTENT_COUNT: extent_count <= cfg_data[4:0];
          CFG_FILE_USABLE:  file_usable <= cfg_data[0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        case (req_type_t'(in_data.req_type))
          REQ_LOAD_EXTENT: begin
            ext_base[in_data.slot_index] <= in_data.item_offset;
            ext_length[in_data.slot_index] <= in_data.item_length;
            ext_device[in_data.slot_index] <= in_data.dev_num;
            ext_chunk[in_data.slot_index] <= in_data.chunk_bytes;
            ext_strips[in_data.slot_index] <= in_data.strip_count;
          end
          REQ_LOAD_STRIP: begin
            strip_base[in_data.slot_index * NSTR + in_data.strip_index] <=
                in_data.item_offset;
            strip_dev[in_data.slot_index * NSTR + in_data.strip_index] <=
                in_data.dev_num;
          end
          REQ_DEV_STATUS: begin
            dev_ok[in_data.dev_num] <= in_data.dev_valid;
            dev_failed[in_data.dev_num] <= in_data.dev_error;
          end
          default: begin
            st = resolve_offset(64'(in_data.item_offset), 64'(in_data.item_length),
                                addr, mlen, dev);
            exp_map.dax_address = addr[47:0];
            exp_map.map_file_offset = in_data.item_offset;
            exp_map.map_length = mlen[47:0];
            exp_map.map_device = dev;
            exp_map.map_status = st;
            exp_map.out_flags = in_data.access_flags;
            expected_maps.push_back(exp_map);
          end
        endcase
      end
    end
  end

  // Compare each result transaction with the oldest expected map
  always @(posedge clk) begin
    out_item_t exp_map;
    if (!rst_n) begin
      mismatches = 0;
    end else if (out_valid && !out_stall) begin
      if (expected_maps.size() == 0) begin
        $error("unexpected result transaction: %p", out_data);
        mismatches++;
      end else begin
        exp_map = expected_maps.pop_front();
        if (out_data.dax_address !== exp_map.dax_address) begin
          $error("dax_address expected %h actual %h",
                 exp_map.dax_address, out_data.dax_address);
          mismatches++;
        end
        if (out_data.map_file_offset !== exp_map.map_file_offset) begin
          $error("map_file_offset expected %h actual %h",
                 exp_map.map_file_offset, out_data.map_file_offset);
          mismatches++;
        end
        if (out_data.map_length !== exp_map.map_length) begin
          $error("map_length expected %h actual %h",
                 exp_map.map_length, out_data.map_length);
          mismatches++;
        end
        if (out_data.map_device !== exp_map.map_device) begin
          $error("map_device expected %0d actual %0d",
                 exp_map.map_device, out_data.map_device);
          mismatches++;
        end
        if (out_data.map_status !== exp_map.map_status) begin
          $error("map_status expected %0d actual %0d",
                 exp_map.map_status, out_data.map_status);
          mismatches++;
        end
        if (out_data.out_flags !== exp_map.out_flags) begin
          $error("out_flags expected %h actual %h",
                 exp_map.out_flags, out_data.out_flags);
          mismatches++;
        end
      end
    end
  end

endmodule

// ===== verif/file_to_device_extent_translate_tb.sv =====
`timescale 1ns / 100ps

module file_to_device_extent_translate_tb;
  import fdet_pkg::*;

  localparam int SETTLE_CYCLES = 200;
  localparam int STALL_LIMIT   = 5000;
  localparam int ITEMS_PER_PHASE = 150;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [47:0] cfg_data = '0;
  int          mismatches;
  int          pending;

  int          send_idle_pct = 18;
  int          recv_idle_pct = 70;
  int          sent_count = 0;
  int          quiet_cycles = 0;

  // Stimulus copy of the settings, used only to aim offsets
  logic [47:0] cur_fsize = '0;
  logic        cur_interleaved = 1'b0;
  logic [4:0]  cur_extent_count = 5'd1;
  logic [47:0] loaded_length [MAX_EXTENTS_DEF];

  file_to_device_extent_translate i_dut (
    .clk, .rst_n, .in_valid, .in_stall, .in_data, .out_valid, .out_stall,
    .out_data, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  file_to_device_extent_translate_checker i_checker (
    .clk, .rst_n, .in_valid, .in_stall, .in_data, .out_valid, .out_stall,
    .out_data, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data, .mismatches,
    .pending
  );

  always #6 clk = ~clk;

  // Randomly stall the result channel
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Drop the run if nothing moves for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready) || !rst_n) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("file_to_device_extent_translate_tb: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [47:0] rand48();
    return 48'({$urandom, $urandom});
  endfunction

  function automatic in_item_t random_item();
    logic [191:0] bits;
    for (int i = 0; i < 6; i++) bits[i*32 +: 32] = $urandom;
    return in_item_t'(bits[$bits(in_item_t)-1:0]);
  endfunction

  function automatic in_item_t extent_load(logic [3:0] slot);
    in_item_t it;
    int r;
    it = random_item();
    it.req_type = REQ_LOAD_EXTENT;
    it.slot_index = slot;
    r = $urandom_range(99);
    if (r < 70) it.item_length = 48'($urandom_range(1, 1 << 20));
    else if (r < 80) it.item_length = '0;
    else it.item_length = rand48();
    r = $urandom_range(99);
    if (r < 80) it.chunk_bytes = 33'($urandom_range(1, 4096));
    else if (r < 88) it.chunk_bytes = '0;
    else if (r < 92) it.chunk_bytes = 33'h1_0000_0000;
    r = $urandom_range(99);
    if (r < 85) it.strip_count = 5'($urandom_range(1, MAX_STRIPS_DEF));
    return it;
  endfunction

  function automatic in_item_t strip_load(logic [3:0] slot, logic [3:0] strip);
    in_item_t it;
    it = random_item();
    it.req_type = REQ_LOAD_STRIP;
    it.slot_index = slot;
    it.strip_index = strip;
    return it;
  endfunction

  function automatic in_item_t device_load(logic [2:0] dev);
    in_item_t it;
    it = random_item();
    it.req_type = REQ_DEV_STATUS;
    it.dev_num = dev;
    it.dev_valid = ($urandom_range(99) < 85);
    it.dev_error = ($urandom_range(99) < 15);
    return it;
  endfunction

  // Aim most offsets inside the mapped span of the file
  function automatic in_item_t translate_req();
    in_item_t it;
    logic [63:0] span, sz;
    int n, r;
    it = random_item();
    it.req_type = REQ_TRANSLATE;
    n = (cur_extent_count > MAX_EXTENTS_DEF) ? MAX_EXTENTS_DEF : int'(cur_extent_count);
    span = 0;
    for (int i = 0; i < n; i++) begin
      sz = 64'(loaded_length[i]);
      if (cur_interleaved && 64'(cur_fsize) < sz) sz = 64'(cur_fsize);
      span += sz;
    end
    r = $urandom_range(99);
    if (r < 80) it.item_offset = 48'({$urandom, $urandom} % (span + span / 8 + 1));
    r = $urandom_range(99);
    if (r < 40) it.item_length = 48'($urandom_range(1, 4096));
    else if (r < 50) it.item_length = '0;
    return it;
  endfunction

  task automatic send_item(in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    if (it.req_type == REQ_LOAD_EXTENT) loaded_length[it.slot_index] = it.item_length;
    do @(posedge clk); while (in_stall);
    sent_count++;
    if (sent_count == 450) begin
      send_idle_pct = 70;
      recv_idle_pct = 18;
    end else if (sent_count == 900) begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [47:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_mode(logic [47:0] fsize, logic inter, logic [4:0] count,
                          logic usable);
    wait_idle();
    write_reg(CFG_FSIZE, fsize);
    write_reg(CFG_INTERLEAVED, {47'd0, inter});
    write_reg(CFG_EXTENT_COUNT, {43'd0, count});
    write_reg(CFG_FILE_USABLE, {47'd0, usable});
    cur_fsize = fsize;
    cur_interleaved = inter;
    cur_extent_count = count;
  endtask

  task automatic run_random(int count);
    int r;
    for (int k = 0; k < count; k++) begin
      r = $urandom_range(99);
      if (r < 72) send_item(translate_req());
      else if (r < 82) send_item(extent_load(4'($urandom)));
      else if (r < 94) send_item(strip_load(4'($urandom), 4'($urandom)));
      else send_item(device_load(3'($urandom)));
      // Hold off once until every outstanding map is back
      if (sent_count == 700) begin
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
      end
    end
  endtask

  initial begin
    in_item_t it;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Fill every table entry before any translate reads it
    for (int s = 0; s < MAX_EXTENTS_DEF; s++) begin
      send_item(extent_load(4'(s)));
      for (int t = 0; t < MAX_STRIPS_DEF; t++) send_item(strip_load(4'(s), 4'(t)));
    end
    for (int d = 0; d < MAX_DEVICES_DEF; d++) begin
      it = device_load(3'(d));
      it.dev_valid = 1'b1;
      it.dev_error = 1'b0;
      send_item(it);
    end

    // Directed: file unusable after reset, then field extremes
    it = translate_req();
    send_item(it);
    set_mode(48'hFFFF_FFFF_FFFF, 1'b0, 5'd16, 1'b1);
    for (int k = 0; k < 4; k++) begin
      it = translate_req();
      it.item_offset = (k[0]) ? 48'hFFFF_FFFF_FFFF : 48'd0;
      it.item_length = (k[1]) ? 48'hFFFF_FFFF_FFFF : 48'd0;
      it.access_flags = (k[0]) ? 32'hFFFF_FFFF : 32'd0;
      send_item(it);
    end
    // Directed: invalid device, failed device, then restore
    for (int k = 0; k < 3; k++) begin
      for (int d = 0; d < MAX_DEVICES_DEF; d++) begin
        it = device_load(3'(d));
        it.dev_valid = (k != 0);
        it.dev_error = (k == 1);
        send_item(it);
      end
      it = translate_req();
      it.item_offset = 48'd0;
      send_item(it);
    end
    run_random(ITEMS_PER_PHASE);

    set_mode(48'hFFFF_FFFF_FFFF, 1'b1, 5'd16, 1'b1);
    run_random(ITEMS_PER_PHASE);
    set_mode(48'($urandom_range(1, 1 << 16)), 1'b1, 5'd4, 1'b1);
    run_random(ITEMS_PER_PHASE);
    // Extent count zero walks nothing, an oversized count saturates
    set_mode(48'hFFFF_FFFF_FFFF, 1'b0, 5'd0, 1'b1);
    run_random(40);
    set_mode(48'hFFFF_FFFF_FFFF, 1'b1, 5'd31, 1'b1);
    run_random(ITEMS_PER_PHASE);
    // Zero file size makes every walked extent empty
    set_mode(48'd0, 1'b1, 5'd1, 1'b1);
    run_random(40);
    set_mode(rand48(), 1'b0, 5'd1, 1'b1);
    run_random(ITEMS_PER_PHASE);
    set_mode(rand48(), 1'b1, 5'd8, 1'b0);
    run_random(40);
    set_mode(48'hFFFF_FFFF_FFFF, 1'b1, 5'd16, 1'b1);
    run_random(ITEMS_PER_PHASE);

    wait_idle();
    if (mismatches == 0 && pending == 0) begin
      $display("file_to_device_extent_translate_tb: PASS");
    end else begin
      $display("file_to_device_extent_translate_tb: FAIL");
    end
    $finish;
  end

endmodule
